>>> hdl/itda_pkg.sv
// Package for the int_to_decimal_ascii block: ASCII codes, decimal power table
// and the command and status types between the controller and the datapath.
// No dependencies.
`default_nettype none

package itda_pkg;

    // Widths of the payload fields.
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 4;
    localparam int MAG_W   = 34;  // wide enough for nine times the largest power of ten
    localparam int POS_W   = 4;   // digit position, 0 to 9
    localparam int DIGIT_W = 4;

    // Packed width of the output stream data word.
    localparam int M_TDATA_W = 16;

    // ASCII codes.
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    // Ten to the power of a digit position, as a 34-bit constant.
    function automatic logic [MAG_W-1:0] pow10(input logic [POS_W-1:0] p);
        logic [MAG_W-1:0] r;
        begin
            unique case (p)
                4'd0:    r = 34'd1;
                4'd1:    r = 34'd10;
                4'd2:    r = 34'd100;
                4'd3:    r = 34'd1000;
                4'd4:    r = 34'd10000;
                4'd5:    r = 34'd100000;
                4'd6:    r = 34'd1000000;
                4'd7:    r = 34'd10000000;
                4'd8:    r = 34'd100000000;
                4'd9:    r = 34'd1000000000;
                default: r = 34'd0;
            endcase
            return r;
        end
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the input word and its sign
        logic count;       // size the number and set the first digit position
        logic emit_sign;   // place a minus sign in the output register
        logic emit_digit;  // place the current digit in the output register
    } itda_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;    // output register can take a character this cycle
        logic neg;         // the captured number is negative
        logic pos_zero;    // the current digit is the last one
    } itda_status_t;

endpackage

`default_nettype wire

>>> hdl/itda_ctrl.sv
// Controller state machine of the int_to_decimal_ascii block.
// Depends on itda_pkg for the command and status types.
`default_nettype none

module itda_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  itda_pkg::itda_status_t status,
    output itda_pkg::itda_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_COUNT = 2'd1;
    localparam logic [1:0] ST_SIGN  = 2'd2;
    localparam logic [1:0] ST_DIGIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT: begin
                cmd.count  = 1'b1;
                state_next = status.neg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN: begin
                if (status.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (status.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (status.pos_zero) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/itda_datapath.sv
// Datapath of the int_to_decimal_ascii block: magnitude register, digit
// extractor over powers of ten, and the output character register.
// Depends on itda_pkg.
`default_nettype none

module itda_datapath (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire  [itda_pkg::VALUE_W-1:0]       in_value,
    input  wire                                in_signed_mode,
    input  itda_pkg::itda_cmd_t                cmd,
    output itda_pkg::itda_status_t             status,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [itda_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);

    logic [itda_pkg::MAG_W-1:0]   mag_reg;
    logic [itda_pkg::MAG_W-1:0]   mag_next;
    logic                         neg_reg;
    logic [itda_pkg::POS_W-1:0]   pos_reg;
    logic [itda_pkg::COUNT_W-1:0] total_reg;
    logic                         out_valid_reg;
    logic [itda_pkg::CHAR_W-1:0]  out_char_reg;
    logic                         out_last_reg;
    logic [itda_pkg::COUNT_W-1:0] out_count_reg;

    logic                         in_neg;
    logic [itda_pkg::VALUE_W-1:0] in_mag;
    logic [itda_pkg::COUNT_W-1:0] num_digits;
    logic [itda_pkg::DIGIT_W-1:0] digit;
    logic [itda_pkg::MAG_W-1:0]   digit_weight;
    logic [itda_pkg::MAG_W-1:0]   pos_weight;

    // Sign and magnitude of the incoming word; the most negative value wraps
    // to its own unsigned magnitude.
    assign in_neg = in_signed_mode && in_value[itda_pkg::VALUE_W-1];
    assign in_mag = in_neg ? (~in_value + 32'd1) : in_value;

    // Number of decimal digits: one plus the powers of ten from ten upward not above the magnitude.
    always_comb begin
        num_digits = 4'd1;
        for (int k = 1; k <= 9; k++) begin
            if (mag_reg >= itda_pkg::pow10(4'(k))) begin
                num_digits = num_digits + 4'd1;
            end
        end
    end

    // Digit at the current position: largest multiple of the position weight
    // that still fits in the remaining magnitude.
    assign pos_weight = itda_pkg::pow10(pos_reg);

    always_comb begin
        digit        = '0;
        digit_weight = '0;
        for (int d = 1; d <= 9; d++) begin
            if (mag_reg >= (34'(d) * pos_weight)) begin
                digit        = 4'(d);
                digit_weight = 34'(d) * pos_weight;
            end
        end
        mag_next = mag_reg - digit_weight;
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg <= {2'b00, in_mag};
            neg_reg <= in_neg;
        end
        if (cmd.count) begin
            pos_reg   <= num_digits - 4'd1;
            total_reg <= num_digits + {3'b000, neg_reg};
        end
        if (cmd.emit_digit) begin
            mag_reg <= mag_next;
            if (pos_reg != '0) begin
                pos_reg <= pos_reg - 4'd1;
            end
        end
    end

    // Output character register; the payload needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_sign || cmd.emit_digit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_sign) begin
            out_char_reg  <= itda_pkg::ASCII_MINUS;
            out_last_reg  <= 1'b0;
            out_count_reg <= '0;
        end else if (cmd.emit_digit) begin
            out_char_reg  <= itda_pkg::ASCII_ZERO + {4'b0000, digit};
            out_last_reg  <= (pos_reg == '0);
            out_count_reg <= (pos_reg == '0) ? total_reg : 4'd0;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign status.neg      = neg_reg;
    assign status.pos_zero = (pos_reg == '0);

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0000, out_count_reg, out_char_reg};

endmodule

`default_nettype wire

>>> hdl/int_to_decimal_ascii.sv
// Top level of the int_to_decimal_ascii block: binary word to decimal ASCII text.
// Instantiates itda_ctrl and itda_datapath; depends on itda_pkg.
//
// Usage:
//   The slave channel takes one 32-bit word in s_tdata with a mode flag in
//   s_tuser (1 reads the word as two's complement, 0 as unsigned). The master
//   channel returns the decimal text one character per transaction, most
//   significant digit first, with a leading minus sign for negative values.
//   m_tdata[7:0] holds the ASCII code and m_tdata[11:8] the total character
//   count on the final character (0 elsewhere); m_tlast marks that character.
//   Timing: a word is accepted in the idle state and sized in the count state,
//   and then, while the receiver does not stall, one character per cycle is
//   loaded into the output register. The digit extractor resolves one decimal
//   digit per cycle against a table of powers of ten while the output register
//   is free. s_tready is high only between items.
//   When the receiver stalls, the output register holds its character and
//   the extractor waits; no character is lost or repeated.
//   Reset clears the controller and the output valid flag; nothing is kept
//   between items.
`default_nettype none

module int_to_decimal_ascii (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // value[31:0]
    input  wire         s_tuser,   // signed_mode
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // character[7:0], char_count[11:8], zero[15:12]
    output logic        m_tlast    // last
);

    itda_pkg::itda_cmd_t    cmd;
    itda_pkg::itda_status_t status;

    // Sequencer for load, sizing, sign and digit steps.
    itda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Magnitude, digit extraction and output register.
    itda_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_value       (s_tdata),
        .in_signed_mode (s_tuser),
        .cmd            (cmd),
        .status         (status),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast)
    );

    // The character count is present exactly on the final character.
    a_count_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[11:8] != 4'd0) == m_tlast))
        else $error("character count does not match the last mark");

    // A minus sign is never the final character.
    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[7:0] == itda_pkg::ASCII_MINUS)) |-> !m_tlast)
        else $error("minus sign marked as last character");

    // Every character is a minus sign or a decimal digit.
    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[7:0] == itda_pkg::ASCII_MINUS) ||
                      ((m_tdata[7:0] >= 8'd48) && (m_tdata[7:0] <= 8'd57))))
        else $error("output character outside the decimal alphabet");

    // A character is never emitted in the same cycle a new word is taken.
    a_no_emit_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !(cmd.emit_digit || cmd.emit_sign))
        else $error("character emitted while loading a new word");

endmodule

`default_nettype wire

>>> verif/int_to_decimal_ascii_tb.sv
// Self-checking testbench for int_to_decimal_ascii: drives 32-bit words with a
// signed/unsigned flag and checks every ASCII character that comes back.
// Depends on itda_pkg and the int_to_decimal_ascii RTL.
`timescale 1ns / 1ps

module int_to_decimal_ascii_tb;

    localparam int IDLE_PCT     = 29;      // percent of cycles each side idles
    localparam int RESET_CYCLES = 12;
    localparam int CALM_START   = 800;     // cycle window with no idling at all
    localparam int CALM_END     = 1400;
    localparam int RANDOM_ITEMS = 110;
    localparam int SETTLE       = 30;      // cycles allowed after the last character

    // One number to convert; drain_first holds it back until the text of
    // every earlier number has come out.
    typedef struct {
        logic [itda_pkg::VALUE_W-1:0] value;
        logic                         signed_mode;
        bit                           drain_first;
    } number_item_t;

    // One expected output character.
    typedef struct {
        logic [itda_pkg::CHAR_W-1:0]  ch;
        logic                         last;
        logic [itda_pkg::COUNT_W-1:0] count;
    } text_char_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;
    logic                 m_tlast;

    number_item_t pending_numbers[$];
    text_char_t   expected_text[$];

    int unsigned  cycle_count   = 0;
    int unsigned  numbers_sent  = 0;
    int unsigned  negatives     = 0;
    int unsigned  longest_text  = 0;
    int unsigned  chars_checked = 0;
    int unsigned  error_count   = 0;

    logic         calm;
    logic         drv_valid_next;
    number_item_t drv_item;
    text_char_t   mon_want;

    int_to_decimal_ascii u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // value[31:0]
        .s_tuser  (s_tuser),    // signed_mode
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // character[7:0], char_count[11:8], zero[15:12]
        .m_tlast  (m_tlast)     // last
    );

    // Clock with a 2 ns period.
    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    assign calm = (cycle_count >= CALM_START) && (cycle_count < CALM_END);

    // Queue the decimal text of one word, most significant digit first.
    function automatic void push_decimal_text(input logic [itda_pkg::VALUE_W-1:0] word,
                                              input logic as_signed);
        logic                         is_neg;
        logic [itda_pkg::VALUE_W-1:0] mag;
        logic [3:0]                   digits[10];
        int                           n_digits;
        int                           total;
        text_char_t                   c;
        is_neg   = as_signed && word[itda_pkg::VALUE_W-1];
        mag      = is_neg ? (~word + 1'b1) : word;
        n_digits = 0;
        do begin
            digits[n_digits] = 4'(mag % 10);
            mag              = mag / 10;
            n_digits++;
        end while (mag != 0 && n_digits < 10);
        total = n_digits + (is_neg ? 1 : 0);
        if (is_neg) begin
            c.ch    = itda_pkg::ASCII_MINUS;
            c.last  = 1'b0;
            c.count = '0;
            expected_text.push_back(c);
            negatives++;
        end
        for (int i = n_digits - 1; i >= 0; i--) begin
            c.ch    = itda_pkg::ASCII_ZERO + itda_pkg::CHAR_W'(digits[i]);
            c.last  = (i == 0);
            c.count = (i == 0) ? itda_pkg::COUNT_W'(total) : '0;
            expected_text.push_back(c);
        end
        if (total > longest_text) longest_text = total;
    endfunction

    function automatic void add_number(input logic [itda_pkg::VALUE_W-1:0] value,
                                       input logic signed_mode,
                                       input bit drain_first = 1'b0);
        number_item_t it;
        it.value       = value;
        it.signed_mode = signed_mode;
        it.drain_first = drain_first;
        pending_numbers.push_back(it);
    endfunction

    // Driver: presents queued words, predicts each accepted transaction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            drv_valid_next = s_tvalid;
            if (s_tvalid && s_tready) begin
                push_decimal_text(s_tdata, s_tuser);
                numbers_sent++;
                drv_valid_next = 1'b0;
            end
            if (!drv_valid_next && pending_numbers.size() != 0 &&
                (calm || $urandom_range(99) >= IDLE_PCT)) begin
                if (!pending_numbers[0].drain_first || expected_text.size() == 0) begin
                    drv_item = pending_numbers.pop_front();
                    s_tdata <= drv_item.value;
                    s_tuser <= drv_item.signed_mode;
                    drv_valid_next = 1'b1;
                end
            end
            s_tvalid <= drv_valid_next;
        end
    end

    // Monitor: random backpressure and a field-by-field check of each character.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            if (m_tvalid && m_tready) begin
                if (expected_text.size() == 0) begin
                    $display("%0t: unexpected character: expected none, got tdata %h last %b",
                             $time, m_tdata, m_tlast);
                    error_count++;
                end else begin
                    mon_want = expected_text.pop_front();
                    chars_checked++;
                    if (m_tdata[7:0] != mon_want.ch || m_tlast != mon_want.last ||
                        m_tdata[11:8] != mon_want.count || m_tdata[15:12] != 4'd0) begin
                        $display("%0t: mismatch: expected char %0d last %b count %0d,",
                                 $time, mon_want.ch, mon_want.last, mon_want.count,
                                 " got char %0d last %b count %0d pad %h",
                                 m_tdata[7:0], m_tlast, m_tdata[11:8], m_tdata[15:12]);
                        error_count++;
                    end
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        logic [itda_pkg::VALUE_W-1:0] v;
        logic [itda_pkg::VALUE_W-1:0] p10;

        // Directed part: zero, extremes, most negative value, digit-count edges.
        add_number(32'h0000_0000, 1'b0);
        add_number(32'h0000_0000, 1'b1);
        add_number(32'h8000_0000, 1'b1);
        add_number(32'h8000_0000, 1'b0);
        add_number(32'hFFFF_FFFF, 1'b0);
        add_number(32'hFFFF_FFFF, 1'b1);
        add_number(32'h7FFF_FFFF, 1'b1);
        add_number(32'h7FFF_FFFF, 1'b0);
        add_number(32'd1, 1'b1);
        add_number(32'd9, 1'b0);
        add_number(32'd10, 1'b1);
        add_number(32'd99, 1'b0);
        add_number(32'd100, 1'b1);
        add_number(32'd999999999, 1'b0);
        add_number(32'd1000000000, 1'b1);
        add_number(-32'sd10, 1'b1);
        add_number(-32'sd1000000000, 1'b1);
        add_number(-32'sd1000000000, 1'b0, 1'b1);
        add_number(32'h5555_5555, 1'b1);
        add_number(32'hAAAA_AAAA, 1'b1);
        add_number(32'hAAAA_AAAA, 1'b0);

        // Random part: full words, short numbers, powers of ten and negatives.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ($urandom_range(0, 4))
                0: v = $urandom();
                1: v = $urandom_range(0, 999);
                2: begin
                    p10 = 1;
                    repeat ($urandom_range(0, 9)) p10 = p10 * 10;
                    v = p10 + $urandom_range(0, 2) - 1;
                end
                3: v = -$urandom_range(1, 100000);
                default: v = {1'b1, 31'($urandom())};
            endcase
            add_number(v, 1'($urandom_range(0, 1)), n == RANDOM_ITEMS / 2);
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (pending_numbers.size() != 0 || s_tvalid || expected_text.size() != 0);
        repeat (SETTLE) @(posedge aclk);

        if (expected_text.size() != 0) begin
            $display("%0t: %0d expected characters never arrived", $time,
                     expected_text.size());
            error_count++;
        end
        $display("Converted %0d words (%0d negative), checked %0d characters;",
                 numbers_sent, negatives, chars_checked);
        $display("longest text %0d characters, %0d errors.", longest_text, error_count);
        if (error_count == 0) begin
            $display("int_to_decimal_ascii verification clean");
        end else begin
            $display("int_to_decimal_ascii verification failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #200000;
        $display("int_to_decimal_ascii verification failed");
        $finish;
    end

endmodule

>>> files.f
hdl/itda_pkg.sv
hdl/itda_ctrl.sv
hdl/itda_datapath.sv
hdl/int_to_decimal_ascii.sv
verif/int_to_decimal_ascii_tb.sv
